// File: rtl/slcf_pkg.sv
package slcf_pkg;

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] SYNC_RESET = 16'hAA55;

    // one accepted payload item
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [15:0] frame_len;
        logic        last_byte;
    } t_item;

    // byte slot of the frame being sent; SL_SYNC_HI also means no frame open
    typedef enum logic [6:0] {
        SL_SYNC_HI = 7'b0000001,
        SL_SYNC_LO = 7'b0000010,
        SL_LEN_HI  = 7'b0000100,
        SL_LEN_LO  = 7'b0001000,
        SL_DATA    = 7'b0010000,
        SL_CRC_HI  = 7'b0100000,
        SL_CRC_LO  = 7'b1000000
    } t_slot;

    // handshake between input buffer and sequencer
    typedef struct packed {
        logic valid;
        logic pop;
    } t_item_ctl;

    // one byte of CRC update, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/slcf_if.sv
// payload input channel
interface slcf_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic [15:0] frame_len;
    logic        last_byte;

    modport source (output valid, output payload_byte, output frame_len,
                    output last_byte, input ready);
    modport sink   (input valid, input payload_byte, input frame_len,
                    input last_byte, output ready);
endinterface

// framed byte output channel
interface slcf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_run;
    logic       end_of_frame;

    modport source (output valid, output out_byte, output end_of_run,
                    output end_of_frame, input ready);
    modport sink   (input valid, input out_byte, input end_of_run,
                    input end_of_frame, output ready);
endinterface

// sync word write channel
interface slcf_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] sync_word;

    modport source (output valid, output sync_word, input ready);
    modport sink   (input valid, input sync_word, output ready);
endinterface

// File: rtl/slcf_skid.sv
module slcf_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  slcf_pkg::t_item   i_item,
    output slcf_pkg::t_item   o_item,
    input  slcf_pkg::t_item_ctl i_ctl_in,
    output slcf_pkg::t_item_ctl o_ctl
);
    import slcf_pkg::*;

    logic  r_main_v;
    logic  r_skid_v;
    t_item r_main;
    t_item r_skid;
    logic  accept;
    logic  pop;

    // ready is registered: only a full skid slot stalls the source
    assign o_ready = !r_skid_v;
    assign accept  = i_valid && !r_skid_v;
    assign pop     = i_ctl_in.pop && r_main_v;

    assign o_item      = r_main;
    assign o_ctl.valid = r_main_v;
    assign o_ctl.pop   = pop;

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (pop) begin
                r_skid_v <= 1'b0;
            end
        end else if (accept) begin
            if (r_main_v && !pop) begin
                r_skid_v <= 1'b1;
            end else begin
                r_main_v <= 1'b1;
            end
        end else if (pop) begin
            r_main_v <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (accept) begin
            if (r_main_v && !pop) begin
                r_skid <= i_item;
            end else begin
                r_main <= i_item;
            end
        end
    end

endmodule

// File: rtl/slcf_seq.sv
module slcf_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [15:0]         i_sync_word,
    input  slcf_pkg::t_item     i_item,
    input  slcf_pkg::t_item_ctl i_ctl,
    output slcf_pkg::t_item_ctl o_ctl,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_byte,
    output logic                o_end_of_run,
    output logic                o_end_of_frame
);
    import slcf_pkg::*;

    t_slot       r_slot;
    t_slot       n_slot;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic        r_out_v;
    logic [7:0]  r_out_byte;
    logic        r_out_eor;
    logic        r_out_eof;
    logic [15:0] crc_base;
    logic [7:0]  sel_byte;
    logic        feed_crc;
    logic        eor;
    logic        eof;
    logic        load;

    // output register takes a byte when empty or being drained
    assign load = i_ctl.valid && (!r_out_v || i_ready);

    // byte select for the current slot
    always_comb begin
        sel_byte = i_item.payload_byte;
        feed_crc = 1'b1;
        n_slot   = SL_SYNC_HI;
        case (r_slot)
            SL_SYNC_HI: begin
                sel_byte = i_sync_word[15:8];
                n_slot   = SL_SYNC_LO;
            end
            SL_SYNC_LO: begin
                sel_byte = i_sync_word[7:0];
                n_slot   = SL_LEN_HI;
            end
            SL_LEN_HI: begin
                sel_byte = i_item.frame_len[15:8];
                n_slot   = SL_LEN_LO;
            end
            SL_LEN_LO: begin
                sel_byte = i_item.frame_len[7:0];
                n_slot   = SL_DATA;
            end
            SL_DATA: begin
                sel_byte = i_item.payload_byte;
                n_slot   = i_item.last_byte ? SL_CRC_HI : SL_DATA;
            end
            SL_CRC_HI: begin
                sel_byte = r_crc[15:8];
                feed_crc = 1'b0;
                n_slot   = SL_CRC_LO;
            end
            SL_CRC_LO: begin
                sel_byte = r_crc[7:0];
                feed_crc = 1'b0;
                n_slot   = SL_SYNC_HI;
            end
            default: begin
                sel_byte = i_item.payload_byte;
                feed_crc = 1'b0;
                n_slot   = SL_SYNC_HI;
            end
        endcase
    end

    // a new frame restarts the CRC from its seed
    assign crc_base = (r_slot == SL_SYNC_HI) ? CRC_INIT : r_crc;
    assign n_crc    = feed_crc ? crc_byte(crc_base, sel_byte) : r_crc;

    assign eof = (r_slot == SL_CRC_LO);
    assign eor = eof || ((r_slot == SL_DATA) && !i_item.last_byte);

    // item is retired with its last byte
    assign o_ctl.valid = i_ctl.valid;
    assign o_ctl.pop   = load && eor;

    // slot, CRC and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= SL_SYNC_HI;
            r_crc   <= CRC_INIT;
            r_out_v <= 1'b0;
        end else begin
            if (load) begin
                r_slot  <= n_slot;
                r_crc   <= n_crc;
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= sel_byte;
            r_out_eor  <= eor;
            r_out_eof  <= eof;
        end
    end

    assign o_valid        = r_out_v;
    assign o_byte         = r_out_byte;
    assign o_end_of_run   = r_out_eor;
    assign o_end_of_frame = r_out_eof;

endmodule

// File: rtl/sync_length_crc16_framer_unit.sv
// Length-prefixed byte framer. The first payload byte of a frame is sent as
// sync word, payload length (both high byte first) and the byte itself; later
// bytes pass through, and the byte marked last is followed by the
// CRC-16/CCITT-FALSE (poly 0x1021, seed 0xFFFF) over sync, length and payload,
// high byte first. Output is one byte per cycle while the receiver is ready; an
// item yields one byte mid-frame, five bytes when it opens a frame and two more
// when it closes one (seven for a one-byte frame). Input is taken back to back
// through a two-entry buffer whose ready is registered.
// Write the sync word only while no item or output byte is in flight; its two
// bytes are read as the header goes out, so a new value applies to the next
// frame.
module sync_length_crc16_framer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slcf_in_if.sink     i_in,
    slcf_out_if.source  o_out,
    slcf_cfg_if.sink    i_cfg
);
    import slcf_pkg::*;

    logic [15:0] r_sync_word;
    t_item       in_item;
    t_item       buf_item;
    t_item_ctl   buf_ctl;
    t_item_ctl   seq_ctl;

    // sync word register, always writable
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_word <= SYNC_RESET;
        end else if (i_cfg.valid) begin
            r_sync_word <= i_cfg.sync_word;
        end
    end

    assign in_item.payload_byte = i_in.payload_byte;
    assign in_item.frame_len    = i_in.frame_len;
    assign in_item.last_byte    = i_in.last_byte;

    // input buffer
    slcf_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .i_item   (in_item),
        .o_item   (buf_item),
        .i_ctl_in (seq_ctl),
        .o_ctl    (buf_ctl)
    );

    // frame sequencer and output register
    slcf_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sync_word    (r_sync_word),
        .i_item         (buf_item),
        .i_ctl          (buf_ctl),
        .o_ctl          (seq_ctl),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_byte         (o_out.out_byte),
        .o_end_of_run   (o_out.end_of_run),
        .o_end_of_frame (o_out.end_of_frame)
    );

endmodule

// File: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import slcf_pkg::*;

    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 80;
    localparam int CYCLE_LIMIT   = 200000;

    // one byte of the framed stream as the block should send it
    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       frame_end;
    } t_framed_byte;

    // Tracks the framer state and the bytes still owed on the output
    class frame_scoreboard;
        t_framed_byte expected_q[$];
        logic [15:0]  sync_word;
        logic         frame_open;
        logic [15:0]  crc_accum;
        int           errors;
        int           bytes_checked;
        int           items_noted;
        int           frames_closed;

        function new();
            sync_word     = SYNC_RESET;
            frame_open    = 1'b0;
            crc_accum     = CRC_INIT;
            errors        = 0;
            bytes_checked = 0;
            items_noted   = 0;
            frames_closed = 0;
        endfunction

        // bit-serial CRC-16 update, MSB first
        function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] d);
            logic [15:0] c;
            logic        fb;
            c = crc;
            for (int k = 7; k >= 0; k--) begin
                fb = c[15] ^ d[k];
                c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
            end
            return c;
        endfunction

        function void queue_byte(logic [7:0] d, logic feed, logic run_end, logic frame_end);
            t_framed_byte e;
            if (feed) begin
                crc_accum = crc_update(crc_accum, d);
            end
            e.data      = d;
            e.run_end   = run_end;
            e.frame_end = frame_end;
            expected_q.insert(expected_q.size(), e);
        endfunction

        // accepted payload transfer: header on frame open, byte, CRC on last
        function void note_payload(t_item it);
            logic [15:0] crc;
            items_noted++;
            if (!frame_open) begin
                crc_accum = CRC_INIT;
                queue_byte(sync_word[15:8], 1'b1, 1'b0, 1'b0);
                queue_byte(sync_word[7:0], 1'b1, 1'b0, 1'b0);
                queue_byte(it.frame_len[15:8], 1'b1, 1'b0, 1'b0);
                queue_byte(it.frame_len[7:0], 1'b1, 1'b0, 1'b0);
                frame_open = 1'b1;
            end
            queue_byte(it.payload_byte, 1'b1, !it.last_byte, 1'b0);
            if (it.last_byte) begin
                crc = crc_accum;
                queue_byte(crc[15:8], 1'b0, 1'b0, 1'b0);
                queue_byte(crc[7:0], 1'b0, 1'b1, 1'b1);
                frame_open = 1'b0;
                crc_accum  = CRC_INIT;
                frames_closed++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        // accepted output transfer against the oldest expected byte
        task check_result(logic [7:0] d, logic eor, logic eof);
            t_framed_byte e;
            bytes_checked++;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected output byte %02h", d));
                return;
            end
            e = expected_q.pop_front();
            if (d !== e.data) begin
                report($sformatf("out_byte %02h, expected %02h", d, e.data));
            end
            if (eor !== e.run_end) begin
                report($sformatf("end_of_run %b, expected %b (byte %02h)", eor, e.run_end, d));
            end
            if (eof !== e.frame_end) begin
                report($sformatf("end_of_frame %b, expected %b (byte %02h)",
                                 eof, e.frame_end, d));
            end
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    slcf_in_if  in_if();
    slcf_out_if out_if();
    slcf_cfg_if cfg_if();

    frame_scoreboard sb;

    int in_idle_pct   = 0;
    int out_idle_pct  = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int holds_done    = 0;
    int cycle_count   = 0;
    int sync_settings = 1;

    sync_length_crc16_framer_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped at cycle %0d with %0d bytes outstanding",
                     cycle_count, sb.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // output side: check transfers, then pick next ready
    always @(posedge i_clk) begin
        if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            sb.check_result(out_if.out_byte, out_if.end_of_run, out_if.end_of_frame);
        end
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
            holds_done++;
        end
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left--;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    // one payload transfer, with random idle cycles ahead of it
    task automatic send_payload(input logic [7:0] d, input logic [15:0] len, input logic last);
        t_item it;
        it.payload_byte = d;
        it.frame_len    = len;
        it.last_byte    = last;
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.payload_byte <= d;
        in_if.frame_len    <= len;
        in_if.last_byte    <= last;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_payload(it);
    endtask

    // whole frame of random bytes; length only matters on the first byte
    task automatic send_frame(input int n_bytes, input logic [15:0] len_field);
        for (int i = 0; i < n_bytes; i++) begin
            send_payload(8'($urandom_range(0, 255)),
                         (i == 0) ? len_field : 16'($urandom_range(0, 65535)),
                         i == n_bytes - 1);
        end
    endtask

    // random frames, mostly short and mostly with a matching length
    task automatic run_random(input int n_items);
        int          sent;
        int          nb;
        int          pick;
        logic [15:0] lf;
        sent = 0;
        while (sent < n_items) begin
            nb   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            pick = $urandom_range(0, 19);
            if (pick < 13) begin
                lf = 16'(nb);
            end else if (pick < 17) begin
                lf = 16'($urandom_range(0, 65535));
            end else if (pick == 17) begin
                lf = 16'h0000;
            end else begin
                lf = 16'hFFFF;
            end
            send_frame(nb, lf);
            sent += nb;
        end
    endtask

    // stop offering input and wait until every expected byte is out
    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_sync(input logic [15:0] v);
        cfg_if.valid     <= 1'b1;
        cfg_if.sync_word <= v;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        sb.sync_word = v;
        sync_settings++;
    endtask

    initial begin
        in_if.valid        = 1'b0;
        in_if.payload_byte = '0;
        in_if.frame_len    = '0;
        in_if.last_byte    = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.sync_word   = '0;
        out_if.ready       = 1'b0;
        sb = new();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset sync word, field extremes, one-byte frames
        in_idle_pct  = 10;
        out_idle_pct = 30;
        send_payload(8'h00, 16'h0001, 1'b1);
        send_payload(8'hFF, 16'hFFFF, 1'b1);
        // zero length in the header, bytes still go out
        send_payload(8'hA5, 16'h0000, 1'b0);
        send_payload(8'h5A, 16'hFFFF, 1'b0);
        send_payload(8'h80, 16'h0000, 1'b1);
        // header says 2, frame carries 4
        send_payload(8'h01, 16'h0002, 1'b0);
        send_payload(8'h02, 16'h5555, 1'b0);
        send_payload(8'h04, 16'hAAAA, 1'b0);
        send_payload(8'h08, 16'h0002, 1'b1);
        // sync word rewritten while a frame is open: new value on next frame
        send_payload(8'h10, 16'h0005, 1'b0);
        send_payload(8'h20, 16'h0005, 1'b0);
        drain();
        write_sync(16'h0000);
        send_payload(8'h40, 16'h1234, 1'b0);
        send_payload(8'h7F, 16'h0005, 1'b1);
        send_payload(8'hC3, 16'h8000, 1'b1);
        drain();
        write_sync(16'hFFFF);
        send_payload(8'h3C, 16'h7FFF, 1'b1);
        send_frame(3, 16'h0003);

        // output held off while input keeps coming, so the input stalls
        in_idle_pct  = 0;
        out_idle_pct = 0;
        hold_request = HOLD_CYCLES;
        send_frame(14, 16'd14);
        drain();
        write_sync(16'($urandom_range(0, 65535)));

        // sender idles lightly, receiver heavily
        in_idle_pct  = 26;
        out_idle_pct = 65;
        run_random(24);
        drain();
        write_sync(SYNC_RESET);

        // sender idles heavily, receiver lightly
        in_idle_pct  = 65;
        out_idle_pct = 26;
        run_random(24);
        drain();
        write_sync(16'($urandom_range(0, 65535)));

        // full rate, with a second long hold-off in the middle
        in_idle_pct  = 0;
        out_idle_pct = 0;
        run_random(10);
        hold_request = HOLD_CYCLES;
        send_frame(12, 16'd12);
        run_random(10);
        drain();

        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d expected bytes never sent", sb.pending()));
        end
        $display("Framer run: %0d payload items in %0d closed frames, %0d output bytes checked",
                 sb.items_noted, sb.frames_closed, sb.bytes_checked);
        $display("Sync settings used: %0d (incl. all-zero and all-one); output hold-offs: %0d",
                 sync_settings, holds_done);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
